// ----- design/lpht_pkg.sv -----
package lpht_pkg;

  localparam int MAX_SLOTS  = 256;
  localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int KEY_W      = 8;
  localparam int OP_W       = 2;
  localparam int SIZE_W     = 9;
  localparam int PADDR_W    = 2;
  localparam int PDATA_W    = 32;

  // remainder unit: dividend width and bits retired per step
  localparam int DIVIDEND_W    = 32;
  localparam int MOD_BITS_STEP = 4;
  localparam int MOD_STEPS     = DIVIDEND_W / MOD_BITS_STEP;
  localparam int MOD_CNT_W     = $clog2(MOD_STEPS);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [PADDR_W-1:0] REG_TABLE_SIZE = 2'd0;

  // sequencer step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] S_START = 3'd1;
  localparam logic [STEP_W-1:0] S_WAIT  = 3'd2;
  localparam logic [STEP_W-1:0] S_READ  = 3'd3;
  localparam logic [STEP_W-1:0] S_CHECK = 3'd4;
  localparam logic [STEP_W-1:0] S_DONE  = 3'd5;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_PRE_FAIL,
    C_MOD_BUSY,
    C_PROBE_END,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic latch_in;
    logic mod_start;
    logic load_home;
    logic mem_rd;
    logic probe;
    logic emit;
  } act_t;

  typedef struct packed {
    cond_e             cond;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] nxt;
    act_t              act;
  } ucode_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic             success;
    logic [KEY_W-1:0] found_key;
    logic [CNT_W-1:0] occupancy;
  } out_t;

  // control store: jump to jmp when cond holds, else go to nxt
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{cond: C_NEVER, jmp: S_IDLE, nxt: S_IDLE, act: '0};
    case (step)
      S_IDLE: begin
        w.cond = C_NO_IN;     w.jmp = S_IDLE;  w.nxt = S_START; w.act.latch_in = 1'b1;
      end
      S_START: begin
        w.cond = C_PRE_FAIL;  w.jmp = S_DONE;  w.nxt = S_WAIT;  w.act.mod_start = 1'b1;
      end
      S_WAIT: begin
        w.cond = C_MOD_BUSY;  w.jmp = S_WAIT;  w.nxt = S_READ;  w.act.load_home = 1'b1;
      end
      S_READ: begin
        w.cond = C_NEVER;     w.jmp = S_READ;  w.nxt = S_CHECK; w.act.mem_rd = 1'b1;
      end
      S_CHECK: begin
        w.cond = C_PROBE_END; w.jmp = S_DONE;  w.nxt = S_READ;  w.act.probe = 1'b1;
      end
      S_DONE: begin
        w.cond = C_OUT_BUSY;  w.jmp = S_DONE;  w.nxt = S_IDLE;  w.act.emit = 1'b1;
      end
      default: begin
        w.cond = C_NEVER;     w.jmp = S_IDLE;  w.nxt = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/linear_probe_hash_table_top.sv -----
// Channel  Dir  Handshake                 Beat payload
// in       in   in_valid_i / in_stall_o   lpht_pkg::in_t  {opcode, key}
// out      out  out_valid_o / out_stall_i lpht_pkg::out_t {success, found_key, occupancy}
// cfg      in   APB psel/penable/pwrite   table_size at byte address 0
//
// One item at a time; an item probes 1..size slots, but a zero key, opcode 3 or a
// full table on insert fails without probing.
// The home index comes from an 8-step remainder unit (4 bits a cycle); each probe
// costs a read step and a check step on the single-port slot memory.
// Reset clears the 256 slot valid bits at once: no clearing pass, first item right away.
// A finished result waits in the output register while out_stall_i is high; the next
// input beat is taken as soon as the sequencer is back at its idle step.
module linear_probe_hash_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lpht_pkg::in_t                 in_data_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lpht_pkg::out_t                out_data_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpht_pkg::PADDR_W-1:0]  paddr,
  input  logic [lpht_pkg::PDATA_W-1:0]  pwdata,
  output logic [lpht_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [lpht_pkg::SIZE_W-1:0] table_size_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == lpht_pkg::REG_TABLE_SIZE);
  assign prdata = (paddr == lpht_pkg::REG_TABLE_SIZE)
                ? {{(lpht_pkg::PDATA_W - lpht_pkg::SIZE_W){1'b0}}, table_size_q}
                : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= lpht_pkg::SIZE_W'(lpht_pkg::MAX_SLOTS);
    end else if (cfg_wr) begin
      table_size_q <= pwdata[lpht_pkg::SIZE_W-1:0];
    end
  end

  // Effective size: zero acts as one, anything above the store acts as the store.
  logic [lpht_pkg::SIZE_W-1:0] eff_size;
  always_comb begin
    if (table_size_q == '0) begin
      eff_size = lpht_pkg::SIZE_W'(1);
    end else if (table_size_q > lpht_pkg::SIZE_W'(lpht_pkg::MAX_SLOTS)) begin
      eff_size = lpht_pkg::SIZE_W'(lpht_pkg::MAX_SLOTS);
    end else begin
      eff_size = table_size_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: step counter plus control word from the package's control store
  // ---------------------------------------------------------------------------
  logic [lpht_pkg::STEP_W-1:0] pc_q, pc_d;
  lpht_pkg::ucode_t            uw;
  logic                        cond_true;

  logic                        out_valid_q;
  logic                        out_busy;
  logic                        pre_fail;
  logic                        mod_busy;
  logic                        probe_end;

  assign uw       = lpht_pkg::ucode(pc_q);
  assign out_busy = out_valid_q && out_stall_i;

  always_comb begin
    case (uw.cond)
      lpht_pkg::C_NEVER:     cond_true = 1'b0;
      lpht_pkg::C_NO_IN:     cond_true = !in_valid_i;
      lpht_pkg::C_PRE_FAIL:  cond_true = pre_fail;
      lpht_pkg::C_MOD_BUSY:  cond_true = mod_busy;
      lpht_pkg::C_PROBE_END: cond_true = probe_end;
      lpht_pkg::C_OUT_BUSY:  cond_true = out_busy;
      default:               cond_true = 1'b0;
    endcase
    pc_d = cond_true ? uw.jmp : uw.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= lpht_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Take a beat only at the idle step; the output register decouples the far side.
  logic accept;
  assign in_stall_o = (pc_q != lpht_pkg::S_IDLE);
  assign accept     = uw.act.latch_in && in_valid_i;

  // ---------------------------------------------------------------------------
  // Item registers
  // ---------------------------------------------------------------------------
  logic [lpht_pkg::OP_W-1:0]   op_q;
  logic [lpht_pkg::KEY_W-1:0]  key_q;
  logic [lpht_pkg::SIZE_W-1:0] size_q;
  logic [lpht_pkg::CNT_W-1:0]  count_q, count_d;
  logic                        success_q, success_d;
  logic [lpht_pkg::KEY_W-1:0]  found_q, found_d;
  logic                        is_ins;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_data_i.opcode;
      key_q  <= in_data_i.key;
      size_q <= eff_size;
    end
  end

  assign is_ins   = (op_q == lpht_pkg::OP_INSERT);
  // Zero key, undefined opcode or a full table on insert: fail without probing.
  assign pre_fail = (key_q == '0)
                 || ((op_q != lpht_pkg::OP_INSERT) && (op_q != lpht_pkg::OP_SEARCH)
                     && (op_q != lpht_pkg::OP_REMOVE))
                 || (is_ins && ({1'b0, count_q} >= {1'b0, size_q}));

  // ---------------------------------------------------------------------------
  // Home index: sign-extended key masked to 31 bits, modulo size
  // ---------------------------------------------------------------------------
  logic [lpht_pkg::DIVIDEND_W-1:0] dividend;
  logic [lpht_pkg::SIZE_W-1:0]     home_rem;

  assign dividend = {1'b0,
                     {(lpht_pkg::DIVIDEND_W - 1 - lpht_pkg::KEY_W){key_q[lpht_pkg::KEY_W-1]}},
                     key_q};

  lpht_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (uw.act.mod_start),
    .dividend_i (dividend),
    .divisor_i  (size_q),
    .busy_o     (mod_busy),
    .rem_o      (home_rem)
  );

  // ---------------------------------------------------------------------------
  // Slot memory with per-entry valid bits; an invalid entry reads as empty
  // ---------------------------------------------------------------------------
  logic [lpht_pkg::KEY_W-1:0]      slot_mem [lpht_pkg::MAX_SLOTS];
  logic [lpht_pkg::MAX_SLOTS-1:0]  slot_vld_q;
  logic [lpht_pkg::KEY_W-1:0]      rd_data_q;
  logic                            rd_vld_q;
  logic                            mem_we;
  logic [lpht_pkg::KEY_W-1:0]      mem_wdata;

  logic [lpht_pkg::SLOT_IDX_W-1:0] p_q, p_d;
  logic [lpht_pkg::SLOT_IDX_W-1:0] i_q, i_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[p_q] <= mem_wdata;
    end
    if (uw.act.mem_rd) begin
      rd_data_q <= slot_mem[p_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        slot_vld_q[p_q] <= 1'b1;
      end
      if (uw.act.mem_rd) begin
        rd_vld_q <= slot_vld_q[p_q];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Probe check
  // ---------------------------------------------------------------------------
  logic [lpht_pkg::KEY_W-1:0]  slot_val;
  logic                        slot_empty;
  logic                        hit;
  logic                        last_probe;
  logic [lpht_pkg::SIZE_W-1:0] p_inc;

  assign slot_val   = rd_vld_q ? rd_data_q : '0;
  assign slot_empty = (slot_val == '0);
  assign hit        = is_ins ? slot_empty : (!slot_empty && (slot_val == key_q));
  assign last_probe = (({1'b0, i_q} + 1'b1) == size_q);
  assign probe_end  = hit || (!is_ins && slot_empty) || last_probe;
  assign p_inc      = {1'b0, p_q} + 1'b1;

  always_comb begin
    p_d       = p_q;
    i_d       = i_q;
    count_d   = count_q;
    success_d = success_q;
    found_d   = found_q;
    mem_we    = 1'b0;
    mem_wdata = key_q;
    if (accept) begin
      success_d = 1'b0;
      found_d   = '0;
    end
    if (uw.act.load_home) begin
      p_d = home_rem[lpht_pkg::SLOT_IDX_W-1:0];
      i_d = '0;
    end
    if (uw.act.probe) begin
      if (hit) begin
        success_d = 1'b1;
        case (op_q)
          lpht_pkg::OP_INSERT: begin
            mem_we    = 1'b1;
            mem_wdata = key_q;
            count_d   = count_q + 1'b1;
          end
          lpht_pkg::OP_SEARCH: begin
            found_d = key_q;
          end
          lpht_pkg::OP_REMOVE: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
          end
          default: begin
            success_d = 1'b0;
          end
        endcase
      end else begin
        // advance, wrapping at the table size
        p_d = (p_inc == size_q) ? '0 : p_inc[lpht_pkg::SLOT_IDX_W-1:0];
        i_d = i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    i_q       <= i_d;
    success_q <= success_d;
    found_q   <= found_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic           emit;
  lpht_pkg::out_t out_q;

  assign emit = uw.act.emit && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.success   <= success_q;
      out_q.found_key <= found_q;
      out_q.occupancy <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lpht_pkg::CNT_W'(lpht_pkg::MAX_SLOTS))
    else $error("occupancy above slot count");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (pc_q == lpht_pkg::S_START))
    else $error("accepted beat did not start the program");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ((count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
         || (count_q == $past(count_q) - 1'b1)))
    else $error("occupancy moved by more than one");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == lpht_pkg::S_CHECK) |-> ({1'b0, p_q} < size_q))
    else $error("probe index outside table");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(pc_q) == lpht_pkg::S_DONE))
    else $error("result raised outside the done step");
`endif

endmodule

// ----- design/lpht_mod.sv -----
// Iterative remainder: MOD_BITS_STEP dividend bits per cycle, restoring form.
module lpht_mod (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lpht_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [lpht_pkg::SIZE_W-1:0]      divisor_i,
  output logic                             busy_o,
  output logic [lpht_pkg::SIZE_W-1:0]      rem_o
);

  logic                                busy_q, busy_d;
  logic [lpht_pkg::MOD_CNT_W-1:0]      cnt_q, cnt_d;
  logic [lpht_pkg::DIVIDEND_W-1:0]     shift_q, shift_d;
  logic [lpht_pkg::SIZE_W-1:0]         div_q, div_d;
  logic [lpht_pkg::SIZE_W-1:0]         rem_q, rem_d;
  logic [lpht_pkg::SIZE_W-1:0]         rem_step;

  always_comb begin
    logic [lpht_pkg::SIZE_W:0]   t;
    logic [lpht_pkg::SIZE_W-1:0] r;
    r = rem_q;
    for (int b = 0; b < lpht_pkg::MOD_BITS_STEP; b++) begin
      t = {r, shift_q[lpht_pkg::DIVIDEND_W-1-b]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r = t[lpht_pkg::SIZE_W-1:0];
    end
    rem_step = r;
  end

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    div_d   = div_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shift_d = dividend_i;
      div_d   = divisor_i;
      rem_d   = '0;
    end else if (busy_q) begin
      rem_d   = rem_step;
      shift_d = shift_q << lpht_pkg::MOD_BITS_STEP;
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ----- test/linear_probe_hash_table_top_test.sv -----
module linear_probe_hash_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  // opcode with no operation behind it, key that marks an empty slot, and a
  // configuration address that holds no register
  localparam logic [OP_W-1:0]    OP_UNDEF   = 2'd3;
  localparam logic [KEY_W-1:0]   KEY_NONE   = 8'h00;
  localparam logic [PADDR_W-1:0] REG_UNUSED = 2'd3;

  // worst correct gap between two accepted beats: a full 256-slot probe plus
  // the long receiver hold-off and a stall burst, taken several times over
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 100;
  localparam int POOL_KEYS = 8;

  typedef enum logic [1:0] {
    ROW_FREE,   // expectation comes from the table mirror
    ROW_TYPED,  // expectation typed into the row
    ROW_CFG     // configuration write between items
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [PADDR_W-1:0] addr;
    logic [PDATA_W-1:0] wdata;
    in_t                item;
    out_t               want;
  } stim_row_t;

  localparam int NUM_ROWS = 31;

  // Directed walk: empty table, the byte extremes (0x01, 0x7F, 0x80, 0xFF),
  // duplicate insert, removal hole that hides a key further down the chain,
  // zero key and undefined opcode, shrinking below occupied slots, size zero
  // and oversize, a write to an address with no register.
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_SEARCH, 8'h01},   '{1'b0, 8'h00, 9'd0}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_REMOVE, 8'h01},   '{1'b0, 8'h00, 9'd0}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_INSERT, KEY_NONE}, '{1'b0, 8'h00, 9'd0}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_UNDEF,  8'h55},   '{1'b0, 8'h00, 9'd0}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'h01},   '{1'b1, 8'h00, 9'd1}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'hFF},   '{1'b1, 8'h00, 9'd2}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'h80},   '{1'b1, 8'h00, 9'd3}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'h7F},   '{1'b1, 8'h00, 9'd4}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'h01},   '{1'b1, 8'h00, 9'd5}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_SEARCH, 8'hFF},   '{1'b1, 8'hFF, 9'd5}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_SEARCH, KEY_NONE}, '{1'b0, 8'h00, 9'd5}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_REMOVE, 8'h01},   '{1'b1, 8'h00, 9'd4}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_SEARCH, 8'h01},   '{1'b0, 8'h00, 9'd4}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_SEARCH, 8'h7F},   '{1'b1, 8'h7F, 9'd4}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_REMOVE, 8'h80},   '{1'b1, 8'h00, 9'd3}},
    '{ROW_CFG,   REG_TABLE_SIZE, 32'd1, '0, '0},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'h42},   '{1'b0, 8'h00, 9'd3}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_SEARCH, 8'h7F},   '{1'b0, 8'h00, 9'd3}},
    '{ROW_CFG,   REG_TABLE_SIZE, 32'd0, '0, '0},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'h10},   '{1'b0, 8'h00, 9'd3}},
    '{ROW_CFG,   REG_TABLE_SIZE, 32'hFFFF_FFFF, '0, '0},
    '{ROW_CFG,   REG_UNUSED,     32'd1, '0, '0},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_SEARCH, 8'h7F},   '{1'b1, 8'h7F, 9'd3}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_REMOVE, 8'h7F},   '{1'b1, 8'h00, 9'd2}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_REMOVE, 8'hFF},   '{1'b1, 8'h00, 9'd1}},
    '{ROW_TYPED, REG_TABLE_SIZE, 32'd0, '{OP_REMOVE, 8'h01},   '{1'b0, 8'h00, 9'd1}},
    '{ROW_CFG,   REG_TABLE_SIZE, 32'd3, '0, '0},
    '{ROW_FREE,  REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'h05},   '0},
    '{ROW_FREE,  REG_TABLE_SIZE, 32'd0, '{OP_INSERT, 8'h85},   '0},
    '{ROW_FREE,  REG_TABLE_SIZE, 32'd0, '{OP_SEARCH, 8'h85},   '0},
    '{ROW_FREE,  REG_TABLE_SIZE, 32'd0, '{OP_REMOVE, 8'h05},   '0}
  };

  // table sizes of the random phases: the extremes, zero and an oversize value
  localparam int PHASE_SIZE [NUM_PHASES] = '{4, 1, 16, 256, 2, 37, 0, 8, 300, 64};

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_t               out_data_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // mirror of the table: slot contents, occupied count, size register
  logic [KEY_W-1:0]  slot_mirror [MAX_SLOTS];
  int                fill_mirror;
  logic [SIZE_W-1:0] size_mirror;

  out_t expected_results [$];
  int   mismatches = 0;
  int   quiet_cycles = 0;

  int idle_pct = 0;    // sender: chance of an idle cycle before each beat
  int stall_pct = 0;   // receiver: chance of stalling in a cycle
  bit hold_armed = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  out_t observed, wanted;

  linear_probe_hash_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one operation to the mirror and return the result beat it causes.
  function automatic out_t hash_table_apply(input in_t item);
    out_t        res;
    int          span;
    int          home;
    int          p;
    logic [31:0] wide;
    res = '0;
    // size zero acts as one slot, anything past the store acts as the full store
    if (size_mirror == 0) span = 1;
    else if (size_mirror > MAX_SLOTS) span = MAX_SLOTS;
    else span = int'(size_mirror);
    // hash the key as a signed byte, sign-extended, top bit dropped
    wide = {{(32 - KEY_W){item.key[KEY_W-1]}}, item.key} & 32'h7FFF_FFFF;
    home = int'(wide % 32'(span));
    if (item.key != KEY_NONE && item.opcode != OP_UNDEF) begin
      if (item.opcode == OP_INSERT) begin
        // no duplicate check: the first empty slot on the path takes the key
        if (fill_mirror < span) begin
          for (int i = 0; i < span; i++) begin
            p = (home + i) % span;
            if (slot_mirror[p] == KEY_NONE) begin
              slot_mirror[p] = item.key;
              fill_mirror++;
              res.success = 1'b1;
              break;
            end
          end
        end
      end else begin
        // search and remove stop at the first empty slot
        for (int i = 0; i < span; i++) begin
          p = (home + i) % span;
          if (slot_mirror[p] == KEY_NONE) break;
          if (slot_mirror[p] == item.key) begin
            res.success = 1'b1;
            if (item.opcode == OP_SEARCH) begin
              res.found_key = item.key;
            end else begin
              slot_mirror[p] = KEY_NONE;
              if (fill_mirror > 0) fill_mirror--;
            end
            break;
          end
        end
      end
    end
    res.occupancy = CNT_W'(fill_mirror);
    return res;
  endfunction

  // One APB transfer: setup, access until pready, then one cycle with psel low
  // so that back-to-back transfers never raise and drop psel in one step.
  task automatic apb_transfer(input logic [PADDR_W-1:0] addr, input logic write,
                              input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register while the block is idle, then read the size back.
  task automatic write_config(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] rd;
    // drop valid and wait for every outstanding result to come back
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    apb_transfer(addr, 1'b1, data, rd);
    if (addr == REG_TABLE_SIZE) begin
      size_mirror = data[SIZE_W-1:0];
    end
    apb_transfer(REG_TABLE_SIZE, 1'b0, '0, rd);
    if (rd !== PDATA_W'(size_mirror)) begin
      $error("table_size: expected %0d, got %0d", size_mirror, rd);
      mismatches++;
    end
  endtask

  // Offer one input beat, hold it until accepted, and queue its result.
  // Valid stays high on return; the next call lowers or reloads it.
  task automatic offer_item(input in_t item, input bit typed, input out_t typed_want);
    out_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    // keep the mirror in step even where the row carries its own answer
    predicted = hash_table_apply(item);
    expected_results.push_back(typed ? typed_want : predicted);
  endtask

  // Receiver: check each accepted result beat against the oldest expectation,
  // then pick the stall for the next cycle. The long hold-off is counted here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      observed = out_data_o;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: success %0d found_key %0h occupancy %0d",
               observed.success, observed.found_key, observed.occupancy);
        mismatches++;
      end else begin
        wanted = expected_results.pop_front();
        if (observed.success !== wanted.success) begin
          $error("success: expected %0d, got %0d", wanted.success, observed.success);
          mismatches++;
        end
        if (observed.found_key !== wanted.found_key) begin
          $error("found_key: expected %0h, got %0h", wanted.found_key, observed.found_key);
          mismatches++;
        end
        if (observed.occupancy !== wanted.occupancy) begin
          $error("occupancy: expected %0d, got %0d", wanted.occupancy, observed.occupancy);
          mismatches++;
        end
      end
    end
    if (hold_armed && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: count cycles in which no beat moves on the input or output channel and no APB transfer is under way.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [PDATA_W-1:0] rd;
    logic [KEY_W-1:0]   key_pool [POOL_KEYS];
    in_t                item;
    int                 pick;

    foreach (slot_mirror[s]) slot_mirror[s] = KEY_NONE;
    fill_mirror = 0;
    size_mirror = SIZE_W'(256);

    // hold reset low, then release it on a rising edge
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // the size register comes out of reset at the full store
    apb_transfer(REG_TABLE_SIZE, 1'b0, '0, rd);
    if (rd !== PDATA_W'(size_mirror)) begin
      $error("table_size: expected %0d, got %0d", size_mirror, rd);
      mismatches++;
    end

    // directed rows, no idling
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_config(DIRECTED[r].addr, DIRECTED[r].wdata);
      end else begin
        offer_item(DIRECTED[r].item, DIRECTED[r].kind == ROW_TYPED, DIRECTED[r].want);
      end
    end

    // random phases: mostly operations on a small pool of keys so that
    // searches and removes hit, plus some wide-open keys and some noise
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_config(REG_TABLE_SIZE, PDATA_W'(PHASE_SIZE[ph]));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 46; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 46; end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      // hold off the receiver once while beats keep coming, so the block backs up
      if (ph == 4) hold_armed <= 1'b1;
      foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom_range(1, 255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          item.opcode = OP_UNDEF;
          item.key    = KEY_W'($urandom_range(0, 255));
        end else if (pick < 8) begin
          item.opcode = OP_W'($urandom_range(0, 2));
          item.key    = KEY_NONE;
        end else begin
          if (pick < 48) item.opcode = OP_INSERT;
          else if (pick < 76) item.opcode = OP_SEARCH;
          else item.opcode = OP_REMOVE;
          if ($urandom_range(3) == 0) item.key = KEY_W'($urandom_range(1, 255));
          else item.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        end
        offer_item(item, 1'b0, '0);
      end
    end

    // drain: drop valid, wait out every expectation, then watch for strays
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/lpht_pkg.sv
design/lpht_mod.sv
design/linear_probe_hash_table_top.sv
test/linear_probe_hash_table_top_test.sv
